// ===== sv/rsd_pkg.sv =====
// shared types and constants of the row standard deviation block
`timescale 1ns / 1ps
package rsd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 11;
    localparam int SQ_W     = 32;
    localparam int SUM_W    = 43;
    localparam int DEV_W    = 16;
    localparam int ROOT_W   = (SUM_W + 1) / 2;
    localparam int SREM_W   = ROOT_W + 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    // items in flight inside the front that may still push a row
    localparam int FRONT_INFLIGHT = 2;

    localparam int DIV_STEPS  = SUM_W;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [SUM_W-1:0] square_sum;
        logic [LEN_W-1:0] row_length;
    } row_job_t;

    typedef struct packed {
        logic              not_empty;
        logic              room;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage

// ===== sv/rsd_front.sv =====
// front: squares each difference from the mean and sums it over a row
`timescale 1ns / 1ps
module rsd_front
    import rsd_pkg::*;
#(
    parameter int unsigned MAX_ROW_LENGTH = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [SAMPLE_W-1:0] row_mean,
    input  logic [LEN_W-1:0]           row_length,
    output logic                       push,
    output row_job_t                   push_job
);

    localparam int unsigned LEN_MAX_ALL = (1 << LEN_W) - 1;
    localparam int unsigned CAP_INT =
        (MAX_ROW_LENGTH > LEN_MAX_ALL) ? LEN_MAX_ALL : MAX_ROW_LENGTH;
    localparam logic [LEN_W-1:0] LEN_CAP = CAP_INT[LEN_W-1:0];

    logic [LEN_W-1:0]      count_reg;
    logic [LEN_W-1:0]      count_next;
    logic [LEN_W-1:0]      eff_len;
    logic                  row_end;
    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0]     diff_mag;

    logic                  a_valid_reg;
    logic                  a_last_reg;
    logic [SAMPLE_W-1:0]   a_abs_reg;
    logic [LEN_W-1:0]      a_len_reg;

    logic                  b_valid_reg;
    logic                  b_last_reg;
    logic [SQ_W-1:0]       b_sq_reg;
    logic [LEN_W-1:0]      b_len_reg;

    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W:0]        sum_wide;
    logic [SUM_W-1:0]      sum_sat;

    always_comb
    begin
        if (row_length == '0)
            eff_len = LEN_W'(1);
        else if (row_length > LEN_CAP)
            eff_len = LEN_CAP;
        else
            eff_len = row_length;
    end

    assign count_next = count_reg + LEN_W'(1);
    assign row_end    = (count_next >= eff_len);

    assign diff     = {sample[SAMPLE_W-1], sample} - {row_mean[SAMPLE_W-1], row_mean};
    assign diff_mag = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            if (accept)
                count_reg <= row_end ? '0 : count_next;
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            if (b_valid_reg)
                sum_reg <= b_last_reg ? '0 : sum_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        a_abs_reg  <= diff_mag[SAMPLE_W-1:0];
        a_last_reg <= row_end;
        a_len_reg  <= eff_len;
        b_sq_reg   <= a_abs_reg * a_abs_reg;
        b_last_reg <= a_last_reg;
        b_len_reg  <= a_len_reg;
    end

    // saturate on carry out of the sum
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(b_sq_reg);
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    assign push                = b_valid_reg && b_last_reg;
    assign push_job.square_sum = sum_sat;
    assign push_job.row_length = b_len_reg;

endmodule

// ===== sv/rsd_queue.sv =====
// short queue of finished row sums between front and back
`timescale 1ns / 1ps
module rsd_queue
    import rsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  row_job_t      push_job,
    input  logic          pop,
    output row_job_t      head_job,
    output queue_status_t status
);

    row_job_t          slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

    assign head_job         = slots_reg[rd_ptr_reg];
    assign status.count     = count_reg;
    assign status.not_empty = (count_reg != '0);
    // leave room for every row that may still be inside the front
    assign status.room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - FRONT_INFLIGHT - 1));

endmodule

// ===== sv/rsd_back.sv =====
// back: divides a row sum by its length and takes the floor square root
`timescale 1ns / 1ps
module rsd_back
    import rsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_ready,
    input  row_job_t         job,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [DEV_W-1:0] deviation
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]            state_reg;
    logic [STEP_CNT_W-1:0] step_reg;
    logic [SUM_W-1:0]      dvd_reg;
    logic [LEN_W-1:0]      rem_reg;
    logic [LEN_W-1:0]      div_len_reg;
    logic [2*ROOT_W-1:0]   val_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SREM_W-1:0]     srem_reg;
    logic                  out_valid_reg;
    logic [DEV_W-1:0]      out_data_reg;

    logic [LEN_W:0]        rem_sh;
    logic                  div_ge;
    logic [LEN_W:0]        rem_sub;
    logic [LEN_W-1:0]      rem_new;
    logic [SUM_W-1:0]      dvd_new;

    logic [SREM_W-1:0]     srem_sh;
    logic [SREM_W-1:0]     trial;
    logic                  root_ge;
    logic [SREM_W-1:0]     srem_new;
    logic [ROOT_W-1:0]     root_new;
    logic                  out_free;
    logic [DEV_W-1:0]      dev_clamped;

    // restoring division, one quotient bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[SUM_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, div_len_reg});
    assign rem_sub = rem_sh - {1'b0, div_len_reg};
    assign rem_new = div_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
    assign dvd_new = {dvd_reg[SUM_W-2:0], div_ge};

    // digit-by-digit root, two radicand bits per cycle
    assign srem_sh  = {srem_reg[SREM_W-3:0], val_reg[2*ROOT_W-1 -: 2]};
    assign trial    = SREM_W'({root_reg, 2'b01});
    assign root_ge  = (srem_sh >= trial);
    assign srem_new = root_ge ? (srem_sh - trial) : srem_sh;
    assign root_new = {root_reg[ROOT_W-2:0], root_ge};

    assign dev_clamped = (root_reg[ROOT_W-1:DEV_W] != '0) ? {DEV_W{1'b1}}
                                                         : root_reg[DEV_W-1:0];
    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == ST_IDLE) && job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_HOLD) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_ready)
                    begin
                        state_reg <= ST_DIV;
                        step_reg  <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == STEP_CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_ROOT;
                        step_reg  <= '0;
                    end
                    else
                        step_reg <= step_reg + STEP_CNT_W'(1);
                end
                ST_ROOT:
                begin
                    if (step_reg == STEP_CNT_W'(ROOT_STEPS - 1))
                        state_reg <= ST_HOLD;
                    else
                        step_reg <= step_reg + STEP_CNT_W'(1);
                end
                ST_HOLD:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                dvd_reg     <= job.square_sum;
                div_len_reg <= job.row_length;
                rem_reg     <= '0;
            end
            ST_DIV:
            begin
                dvd_reg  <= dvd_new;
                rem_reg  <= rem_new;
                val_reg  <= (2*ROOT_W)'(dvd_new);
                root_reg <= '0;
                srem_reg <= '0;
            end
            ST_ROOT:
            begin
                val_reg  <= {val_reg[2*ROOT_W-3:0], 2'b00};
                srem_reg <= srem_new;
                root_reg <= root_new;
            end
            ST_HOLD:
            begin
                if (out_free)
                    out_data_reg <= dev_clamped;
            end
            default:
                rem_reg <= '0;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign deviation = out_data_reg;

endmodule

// ===== sv/row_standard_deviation.sv =====
// Row standard deviation: streams matrix elements in, one deviation out per row.
// Input stream s_axis: tdata carries sample (bits 15:0) and the row mean (31:16),
// both signed Q8.8; one request per cycle is taken while the row queue has room.
// Output stream m_axis: tdata carries the deviation, unsigned Q8.8, floored,
// one request per completed row.
// cfg_we/cfg_wdata set the row length (0 acts as 1, capped at MAX_ROW_LENGTH);
// write it only while the block is idle.
// The front squares and accumulates at one element per cycle (3 stage pipeline).
// A 4-entry queue holds finished row sums for the back, which runs a restoring
// divide and a two-bit-per-cycle square root on one row at a time: the back pops
// the next row sum only once the last result has been loaded for output.
// Rows stream at one element per cycle while the queue has room; with short
// rows the queue runs out of room and the back sets the pace.
// A finished result waits in an output register; while the receiver stalls the
// back finishes the next row and then waits, and the front keeps accepting while
// the queue has room. Reset clears the row count, the sum, the queue and the
// output valid flag, and sets the row length to 1.
`timescale 1ns / 1ps
module row_standard_deviation
    import rsd_pkg::*;
#(
    parameter int unsigned MAX_ROW_LENGTH = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // sample [15:0], row_mean [31:16]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // deviation [15:0]
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata
);

    logic [LEN_W-1:0] row_length_reg;
    logic             accept;
    logic             push;
    row_job_t         push_job;
    logic             pop;
    row_job_t         head_job;
    queue_status_t    q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_length_reg <= LEN_W'(1);
        else if (cfg_we)
            row_length_reg <= cfg_wdata;
    end

    assign s_axis_tready = q_status.room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    rsd_front #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .sample     (s_axis_tdata[15:0]),
        .row_mean   (s_axis_tdata[31:16]),
        .row_length (row_length_reg),
        .push       (push),
        .push_job   (push_job)
    );

    rsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    rsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_ready (q_status.not_empty),
        .job       (head_job),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .deviation (m_axis_tdata)
    );

    // the front never pushes a row into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_status.count != QCNT_W'(QUEUE_DEPTH) || pop))
        else $error("row queue overflow");

    // the back only pops a row that is there
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.count != '0)
        else $error("row queue underflow");

    // a pushed row leaves the queue non-empty in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> q_status.not_empty)
        else $error("row queue lost a pushed row");

endmodule

// ===== sim/row_standard_deviation_test.sv =====
// testbench of the row standard deviation block: directed and random rows in, each deviation predicted and checked
`timescale 1ns / 1ps
module row_standard_deviation_test
    import rsd_pkg::*;
();

    localparam int MAX_LEN       = 1024;
    localparam int SETTLE_CYCLES = 120;
    localparam int STALL_LIMIT   = 20000;
    localparam int PHASES        = 9;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] row_mean;
        logic signed [SAMPLE_W-1:0] sample;
    } element_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata;   // sample [15:0], row_mean [31:16]
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [15:0]         m_axis_tdata;   // deviation [15:0]
    logic                cfg_we;
    logic [LEN_W-1:0]    cfg_wdata;

    element_t            pending_elements[$];
    logic [DEV_W-1:0]    expected_devs[$];
    logic                in_taken = 1'b0;
    int unsigned         send_idle_pct;
    int unsigned         recv_idle_pct;
    int                  error_count = 0;
    int                  elements_done = 0;
    int                  rows_checked = 0;
    int                  lengths_written = 0;
    int                  quiet_cycles = 0;

    // predictor state
    logic [LEN_W-1:0]    dev_row_length = LEN_W'(1);
    logic [LEN_W-1:0]    dev_count = '0;
    logic [SUM_W-1:0]    dev_sum = '0;

    row_standard_deviation #(
        .MAX_ROW_LENGTH(MAX_LEN)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic int unsigned effective_length(input int unsigned len);
        if (len == 0)
            return 1;
        if (len > MAX_LEN)
            return MAX_LEN;
        return len;
    endfunction

    function automatic logic [DEV_W-1:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        if (root > 64'hFFFF)
            root = 64'hFFFF;
        return root[DEV_W-1:0];
    endfunction

    // squares the difference, adds it to the row sum, predicts a deviation at row end
    task automatic accumulate_element(input element_t e);
        logic [16:0]      diff;
        logic [16:0]      mag;
        logic [SUM_W:0]   total;
        logic [LEN_W-1:0] n;
        diff = {e.sample[15], e.sample} - {e.row_mean[15], e.row_mean};
        mag = diff[16] ? (~diff + 17'd1) : diff;
        total = {1'b0, dev_sum} + (SUM_W + 1)'(mag) * (SUM_W + 1)'(mag);
        if (total[SUM_W])
            total = {1'b0, {SUM_W{1'b1}}};
        dev_sum = total[SUM_W-1:0];
        n = LEN_W'(effective_length(32'(dev_row_length)));
        dev_count = dev_count + 1'b1;
        if (dev_count >= n)
        begin
            expected_devs = {expected_devs, floor_root(64'(dev_sum / n))};
            dev_count = '0;
            dev_sum = '0;
        end
    endtask

    // monitor: tracks config writes, accepted requests and checks results
    always @(posedge clk)
    begin
        logic [DEV_W-1:0] want;
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (cfg_we)
                dev_row_length = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_devs.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected deviation %0d", $time, m_axis_tdata);
                end
                else
                begin
                    want = expected_devs.pop_front();
                    rows_checked++;
                    if (m_axis_tdata !== want)
                    begin
                        error_count++;
                        $display("%0t: deviation mismatch, expected %0d, actual %0d",
                                 $time, want, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                accumulate_element(element_t'(s_axis_tdata));
                elements_done++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // driver: sender and receiver sides
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (pending_elements.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_elements.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic add_element(input logic [15:0] sample, input logic [15:0] mean);
        element_t e;
        e.sample = sample;
        e.row_mean = mean;
        pending_elements = {pending_elements, e};
    endtask

    // mostly rows sharing one mean, with some noise and extremes mixed in
    task automatic queue_rows(input int count, input int unsigned len);
        element_t          e;
        logic [15:0]       mean;
        int unsigned       pos;
        pos = 0;
        mean = 16'($urandom);
        for (int i = 0; i < count; i++)
        begin
            if (pos == 0)
                mean = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(2047)) - 16'd1024;
            e.row_mean = mean;
            case ($urandom_range(9))
                0: e.sample = 16'($urandom);
                1:
                begin
                    e.sample = 16'($urandom);
                    e.row_mean = 16'($urandom);
                end
                2: e.sample = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                default: e.sample = mean + 16'($urandom_range(1023)) - 16'd512;
            endcase
            pending_elements = {pending_elements, e};
            pos = (pos + 1 >= effective_length(len)) ? 0 : pos + 1;
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_elements.size() != 0 || s_axis_tvalid || expected_devs.size() != 0);
        // a partial row may still be in the front pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_length(input logic [LEN_W-1:0] len);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(negedge clk);
        cfg_we    <= 1'b0;
        lengths_written++;
    endtask

    initial
    begin
        int unsigned phase_len[PHASES]   = '{1, 2, 0, 3, 5, 7, 70, 2047, 4};
        int          phase_count[PHASES] = '{20, 20, 20, 30, 30, 35, 140, 1024, 20};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        send_idle_pct = 11;
        recv_idle_pct = 69;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // row length 1 after reset: extremes of the difference
        add_element(16'h7FFF, 16'h8000);
        add_element(16'h8000, 16'h7FFF);
        add_element(16'h0000, 16'h0000);
        add_element(16'h0100, 16'h0000);
        add_element(16'h0001, 16'h0000);
        add_element(16'hFF00, 16'h0100);
        // zero length acts as one
        wait_idle();
        write_row_length(0);
        add_element(16'h1234, 16'hEDCC);
        add_element(16'hFFFF, 16'hFFFF);
        wait_idle();
        write_row_length(3);
        repeat (3) add_element(16'h8000, 16'h7FFF);
        // shortened mid-row: count already meets the new length
        wait_idle();
        write_row_length(4);
        add_element(16'h0300, 16'h0100);
        add_element(16'hFF00, 16'h0100);
        wait_idle();
        write_row_length(2);
        add_element(16'h0500, 16'h0100);
        add_element(16'h7FFF, 16'h0000);
        add_element(16'h8000, 16'h0000);
        // shortened mid-row: count already past the new length
        wait_idle();
        write_row_length(5);
        repeat (3) add_element(16'h4000, 16'hC000);
        wait_idle();
        write_row_length(2);
        add_element(16'h0000, 16'h0080);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            if (p == 3)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 11;
            end
            else if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_row_length(LEN_W'(phase_len[p]));
            queue_rows(phase_count[p], phase_len[p]);
        end

        wait_idle();
        $display("%0d elements streamed under %0d row length writes, %0d deviations checked",
                 elements_done, lengths_written, rows_checked);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
